>>> src/fdep_pkg.sv
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared types and constants of the directory entry parser.
// ----------------------------------------------------------------------------
package fdep_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DESC = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] DELETED_MARK   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam int         ATTR_VOLUME_BIT = 3;
    localparam int         ATTR_DIR_BIT    = 4;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam logic [5:0] LFN_MAX_SEQ    = 6'd20;
    localparam int         LFN_CHARS      = 13;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic        last;
        logic        is_directory;
        logic [7:0]  attributes;
        logic [31:0] size_bytes;
        logic [31:0] first_cluster;
        logic [7:0]  name_char;
        logic [1:0]  kind;
    } t_result;

    // byte offset of long-name character i inside the entry
    function automatic logic [4:0] lfn_offset(input logic [3:0] i);
        case (i)
            4'd0:    lfn_offset = 5'd1;
            4'd1:    lfn_offset = 5'd3;
            4'd2:    lfn_offset = 5'd5;
            4'd3:    lfn_offset = 5'd7;
            4'd4:    lfn_offset = 5'd9;
            4'd5:    lfn_offset = 5'd14;
            4'd6:    lfn_offset = 5'd16;
            4'd7:    lfn_offset = 5'd18;
            4'd8:    lfn_offset = 5'd20;
            4'd9:    lfn_offset = 5'd22;
            4'd10:   lfn_offset = 5'd24;
            4'd11:   lfn_offset = 5'd28;
            4'd12:   lfn_offset = 5'd30;
            default: lfn_offset = 5'd0;
        endcase
    endfunction

endpackage

>>> src/fdep_ram.sv
// ----------------------------------------------------------------------------
// fdep_ram
// Generic RAM with one write port, one read port and registered read.
// ----------------------------------------------------------------------------
module fdep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/fat_directory_entry_parser.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// FAT32 directory entry parser with long-name collection.
// ----------------------------------------------------------------------------
// Bytes come in on the slave stream, one per cycle while the sequencer is
// idle and the output register is free, and fill a 32-byte entry RAM. The
// 32nd byte of an entry starts a sequencer that works through the entry RAM
// and a MAX_NAME-slot long-name RAM (both one-read one-write, registered
// read): S_READ and S_HDR fetch the header bytes 0 and 11, after which a
// deleted or volume entry is done. A long-name start entry writes one 0xFFFF
// slot per cycle; each of the 13 characters is then stored via S_LC0, S_LC1
// and S_LC2, or it ends at S_LC0 with no active name or the sequence out of
// range. A regular entry steps S_LN0, S_LN1 per long-name slot or S_SN0,
// S_SN1 per 8.3 byte examined, one more S_SN1 for the dot, then S_DS0, S_DS1
// per descriptor byte (8 in all) and S_OUT to load it. Every emitted beat
// can further wait on the master side's tready. The input is held off while
// the sequencer runs. tuser on the slave side carries restart; on the master
// side tuser carries kind and tlast marks the final result of an input byte.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser
    import fdep_pkg::*;
#(
    parameter int MAX_NAME = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] dir_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // name_char, first_cluster, size_bytes,
                                        // attributes, is_directory, 7 pad
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);
    localparam int NW = $clog2(MAX_NAME);
    localparam int LW = 7;
    localparam logic [LW-1:0] NAME_CAP = LW'(MAX_NAME - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;  // fetch header bytes 0 and 11
    localparam logic [3:0] S_HDR   = 4'd2;
    localparam logic [3:0] S_FILL  = 4'd3;  // write 0xFFFF slots
    localparam logic [3:0] S_LC0   = 4'd4;  // long char low byte read
    localparam logic [3:0] S_LC1   = 4'd5;
    localparam logic [3:0] S_LC2   = 4'd6;
    localparam logic [3:0] S_LN0   = 4'd7;  // long name emit read
    localparam logic [3:0] S_LN1   = 4'd8;
    localparam logic [3:0] S_SN0   = 4'd9;  // short name read
    localparam logic [3:0] S_SN1   = 4'd10;
    localparam logic [3:0] S_DS0   = 4'd11; // descriptor byte reads
    localparam logic [3:0] S_DS1   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13; // wait for output slot

    logic [3:0]  r_state;
    logic [4:0]  r_pos;
    logic [LW-1:0] r_len;
    logic        r_active, r_ended;
    logic [7:0]  r_b0, r_attr;
    logic [LW-1:0] r_idx;
    logic [3:0]  r_ci;
    logic [7:0]  r_lo;
    logic [4:0]  r_dsi;
    logic [31:0] r_cl, r_sz;
    logic        r_dot_done;
    logic        r_vld;
    t_result     r_out;

    // entry RAM
    logic        e_we;
    logic [4:0]  e_waddr, e_raddr;
    logic [7:0]  e_wdata, e_rdata;
    // long-name RAM
    logic        l_we;
    logic [NW-1:0] l_waddr, l_raddr;
    logic [15:0] l_wdata, l_rdata;

    fdep_ram #(.WIDTH(8), .DEPTH(32)) u_entry (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    fdep_ram #(.WIDTH(16), .DEPTH(MAX_NAME)) u_lname (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    logic out_free;
    assign out_free = !r_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    logic [5:0] seq;
    assign seq = r_b0[5:0];
    logic [LW+3:0] base_full;
    assign base_full = (LW+4)'(seq - 6'd1) * (LW+4)'(LFN_CHARS);
    logic [LW+3:0] slot_full;
    assign slot_full = base_full + (LW+4)'(r_ci);
    logic [4:0] char_off;
    assign char_off = lfn_offset(r_ci);

    // descriptor byte order: 20,21,26,27,28,29,30,31
    function automatic logic [4:0] ds_addr(input logic [4:0] k);
        case (k)
            5'd0:    ds_addr = 5'd20;
            5'd1:    ds_addr = 5'd21;
            5'd2:    ds_addr = 5'd26;
            5'd3:    ds_addr = 5'd27;
            5'd4:    ds_addr = 5'd28;
            5'd5:    ds_addr = 5'd29;
            5'd6:    ds_addr = 5'd30;
            default: ds_addr = 5'd31;
        endcase
    endfunction

    always_comb begin
        e_we = s_acc && !(s_axis_tuser ? 1'b0 : r_ended);
        e_waddr = s_axis_tuser ? 5'd0 : r_pos;
        e_wdata = s_axis_tdata;
        e_raddr = 5'd0;
        l_we = 1'b0;
        l_waddr = r_idx[NW-1:0];
        l_wdata = 16'hFFFF;
        l_raddr = r_idx[NW-1:0];
        case (r_state)
            S_READ:  e_raddr = 5'd11;
            S_LC0:   e_raddr = char_off;
            S_LC1:   e_raddr = char_off + 5'd1;
            // hold the byte address while a name beat waits
            S_SN0, S_SN1: e_raddr = r_idx[4:0];
            S_DS0:   e_raddr = ds_addr(r_dsi);
            S_FILL:  l_we = 1'b1;
            S_LC2: begin
                l_we = (slot_full < (LW+4)'(MAX_NAME));
                l_waddr = slot_full[NW-1:0];
                l_wdata = {e_rdata, r_lo};
            end
            default: ;
        endcase
    end

    logic [LW-1:0] lfn_len;
    always_comb begin
        logic [LW+3:0] t;
        t = (LW+4)'(seq) * (LW+4)'(LFN_CHARS);
        lfn_len = (t > (LW+4)'(NAME_CAP)) ? NAME_CAP : t[LW-1:0];
    end

    logic short_stop;
    assign short_stop = (r_idx[3:0] == 4'd8) && !r_dot_done;

    always_ff @(posedge i_clk) begin
        logic n_vld;
        n_vld = r_vld && !m_axis_tready;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos <= '0;
            r_len <= '0;
            r_active <= 1'b0;
            r_ended <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        logic [4:0] p;
                        logic       ed;
                        p  = s_axis_tuser ? 5'd0 : r_pos;
                        ed = s_axis_tuser ? 1'b0 : r_ended;
                        if (s_axis_tuser) begin
                            r_len <= '0;
                            r_active <= 1'b0;
                        end
                        // drop bytes after the end marker until a restart
                        if (ed) begin
                        end else if (p == 5'd0 && s_axis_tdata == 8'h00) begin
                            r_ended <= 1'b1;
                            r_pos <= '0;
                            r_out <= '{last: 1'b1, is_directory: 1'b0,
                                       attributes: '0, size_bytes: '0,
                                       first_cluster: '0, name_char: '0,
                                       kind: KIND_END};
                            n_vld = 1'b1;
                        end else if (p == 5'd31) begin
                            r_ended <= 1'b0;
                            r_pos <= '0;
                            r_state <= S_READ;
                        end else begin
                            r_ended <= 1'b0;
                            r_pos <= p + 5'd1;
                        end
                    end
                end
                S_READ: begin
                    r_b0 <= e_rdata;  // byte 0 read at idle address
                    r_state <= S_HDR;
                end
                S_HDR: begin
                    r_attr <= e_rdata;
                    r_idx <= '0;
                    r_ci <= '0;
                    r_dsi <= '0;
                    r_dot_done <= 1'b0;
                    if (r_b0 == DELETED_MARK || (e_rdata != ATTR_LONG_NAME &&
                        e_rdata[ATTR_VOLUME_BIT])) begin
                        r_active <= 1'b0;
                        r_len <= '0;
                        r_state <= S_IDLE;
                    end else if (e_rdata == ATTR_LONG_NAME) begin
                        if (r_b0[6]) begin
                            r_len <= lfn_len;
                            r_active <= 1'b1;
                            r_state <= (lfn_len == '0) ? S_LC0 : S_FILL;
                        end else begin
                            r_state <= S_LC0;
                        end
                    end else if (r_active && r_len != '0) begin
                        r_state <= S_LN0;
                    end else begin
                        r_state <= S_SN0;
                    end
                end
                S_FILL: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_len) r_state <= S_LC0;
                end
                S_LC0: begin
                    if (!(r_active && seq >= 6'd1 && seq <= LFN_MAX_SEQ))
                        r_state <= S_IDLE;
                    else
                        r_state <= S_LC1;
                end
                S_LC1: begin
                    r_lo <= e_rdata;
                    r_state <= S_LC2;
                end
                S_LC2: begin
                    r_ci <= r_ci + 4'd1;
                    r_state <= (r_ci == 4'(LFN_CHARS - 1)) ? S_IDLE : S_LC0;
                end
                S_LN0: begin
                    r_state <= (r_idx == r_len) ? S_DS0 : S_LN1;
                end
                S_LN1: begin
                    if (l_rdata == 16'h0000 || l_rdata == 16'hFFFF) begin
                        r_state <= S_DS0;
                    end else if (out_free) begin
                        r_out <= '{last: 1'b0, is_directory: 1'b0,
                                   attributes: '0, size_bytes: '0,
                                   first_cluster: '0,
                                   name_char: {1'b0, l_rdata[6:0]},
                                   kind: KIND_CHAR};
                        n_vld = 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_LN0;
                    end
                end
                S_SN0: begin
                    r_state <= (r_idx == LW'(11)) ? S_DS0 : S_SN1;
                end
                S_SN1: begin
                    if (short_stop && e_rdata == SPACE_CHAR) begin
                        r_state <= S_DS0;
                    end else if (short_stop) begin
                        if (out_free) begin
                            r_out <= '{last: 1'b0, is_directory: 1'b0,
                                       attributes: '0, size_bytes: '0,
                                       first_cluster: '0, name_char: DOT_CHAR,
                                       kind: KIND_CHAR};
                            n_vld = 1'b1;
                            r_dot_done <= 1'b1;
                        end
                    end else if (e_rdata == SPACE_CHAR) begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SN0;
                    end else if (out_free) begin
                        r_out <= '{last: 1'b0, is_directory: 1'b0,
                                   attributes: '0, size_bytes: '0,
                                   first_cluster: '0, name_char: e_rdata,
                                   kind: KIND_CHAR};
                        n_vld = 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SN0;
                    end
                end
                S_DS0: r_state <= S_DS1;
                S_DS1: begin
                    case (r_dsi)
                        5'd0: r_cl[23:16] <= e_rdata;
                        5'd1: r_cl[31:24] <= e_rdata;
                        5'd2: r_cl[7:0]   <= e_rdata;
                        5'd3: r_cl[15:8]  <= e_rdata;
                        5'd4: r_sz[7:0]   <= e_rdata;
                        5'd5: r_sz[15:8]  <= e_rdata;
                        5'd6: r_sz[23:16] <= e_rdata;
                        default: r_sz[31:24] <= e_rdata;
                    endcase
                    r_dsi <= r_dsi + 5'd1;
                    r_state <= (r_dsi == 5'd7) ? S_OUT : S_DS0;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out <= '{last: 1'b1, is_directory: r_attr[ATTR_DIR_BIT],
                                   attributes: r_attr, size_bytes: r_sz,
                                   first_cluster: r_cl, name_char: '0,
                                   kind: KIND_DESC};
                        n_vld = 1'b1;
                        r_active <= 1'b0;
                        r_len <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_vld <= n_vld;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.is_directory, r_out.attributes,
                            r_out.size_bytes, r_out.first_cluster, r_out.name_char};
endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT32 directory entry parser.
// ----------------------------------------------------------------------------
// Drive a directed table of bytes (end marker, short names, long names,
// deleted and volume entries, restarts), then random directory streams of
// mostly well-formed entries with random content. Predict every result beat
// with a behavioral model of the parser and compare every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import fdep_pkg::*;

    localparam int MAX_NAME   = 64;
    localparam int CYCLE_CAP  = 1000000;
    localparam int MAX_REPORT = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    fat_directory_entry_parser #(.MAX_NAME(MAX_NAME)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    logic [7:0]  ent_buf [32];
    logic [4:0]  ent_pos;
    logic [15:0] lfn_buf [MAX_NAME];
    logic [6:0]  lfn_len;
    logic        lfn_on;
    logic        dir_done;

    t_result     beats_due[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          hold_sink = 1'b0;
    int          sink_wait = 0;

    function automatic logic [15:0] ent_le16(int p);
        return {ent_buf[(p + 1) % 32], ent_buf[p % 32]};
    endfunction

    function automatic void push_beat(logic [1:0] k, logic [7:0] ch, logic [31:0] cl,
                                      logic [31:0] sz, logic [7:0] at);
        t_result r;
        r = '0;
        r.kind = k;
        r.name_char = ch;
        r.first_cluster = cl;
        r.size_bytes = sz;
        r.attributes = at;
        r.is_directory = (k == KIND_DESC) ? at[ATTR_DIR_BIT] : 1'b0;
        beats_due.push_back(r);
    endfunction

    function automatic void decode_entry();
        logic [7:0] b0;
        logic [7:0] at;
        int seq;
        int len;
        int base;
        begin
            b0 = ent_buf[0];
            at = ent_buf[11];
            if (b0 == DELETED_MARK || (at != ATTR_LONG_NAME && at[ATTR_VOLUME_BIT])) begin
                lfn_on = 1'b0;
                lfn_len = '0;
                return;
            end
            if (at == ATTR_LONG_NAME) begin
                seq = b0 & 8'h3F;
                if (b0[6]) begin
                    len = seq * LFN_CHARS;
                    if (len > MAX_NAME - 1) len = MAX_NAME - 1;
                    lfn_len = len[6:0];
                    lfn_on = 1'b1;
                    for (int i = 0; i < len; i++) lfn_buf[i] = 16'hFFFF;
                end
                if (lfn_on && seq >= 1 && seq <= LFN_MAX_SEQ) begin
                    base = (seq - 1) * LFN_CHARS;
                    for (int i = 0; i < LFN_CHARS && base + i < MAX_NAME; i++)
                        lfn_buf[base + i] = ent_le16(lfn_offset(i[3:0]));
                end
                return;
            end
            if (lfn_on && lfn_len > 0) begin
                for (int i = 0; i < lfn_len && i < MAX_NAME - 1; i++) begin
                    if (lfn_buf[i] == 16'h0000 || lfn_buf[i] == 16'hFFFF) break;
                    push_beat(KIND_CHAR, {1'b0, lfn_buf[i][6:0]}, '0, '0, '0);
                end
            end else begin
                for (int i = 0; i < 8; i++)
                    if (ent_buf[i] != SPACE_CHAR) push_beat(KIND_CHAR, ent_buf[i], '0, '0, '0);
                if (ent_buf[8] != SPACE_CHAR) begin
                    push_beat(KIND_CHAR, DOT_CHAR, '0, '0, '0);
                    for (int i = 8; i < 11; i++)
                        if (ent_buf[i] != SPACE_CHAR)
                            push_beat(KIND_CHAR, ent_buf[i], '0, '0, '0);
                end
            end
            push_beat(KIND_DESC, '0, {ent_le16(20), ent_le16(26)},
                      {ent_le16(30), ent_le16(28)}, at);
            lfn_on = 1'b0;
            lfn_len = '0;
        end
    endfunction

    // Advance the model by one accepted byte; mark the final beat it causes.
    function automatic void predict_byte(logic [7:0] b, logic rs);
        int n0;
        begin
            n0 = beats_due.size();
            if (rs) begin
                ent_pos = '0;
                lfn_len = '0;
                lfn_on = 1'b0;
                dir_done = 1'b0;
            end
            if (dir_done) return;
            ent_buf[ent_pos] = b;
            if (ent_pos == 0 && b == 8'h00) begin
                dir_done = 1'b1;
                push_beat(KIND_END, '0, '0, '0, '0);
            end else if (ent_pos == 5'd31) begin
                ent_pos = '0;
                decode_entry();
            end else begin
                ent_pos = ent_pos + 1'b1;
            end
            if (beats_due.size() > n0) beats_due[$].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- sink
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '0;
                {got.is_directory, got.attributes, got.size_bytes,
                 got.first_cluster, got.name_char} = m_axis_tdata[80:0];
                got.kind = m_axis_tuser;
                got.last = m_axis_tlast;
                if (beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("unexpected beat %h", got);
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
                // draw the idle cycles before the next beat
                sink_wait = $urandom_range(0, 4);
            end else if (sink_wait > 0) begin
                sink_wait = sink_wait - 1;
            end
            m_axis_tready <= !hold_sink && (sink_wait == 0);
        end
    end

    // Long receiver stall, counted in its own process.
    initial begin
        wait (cycles > 1000);
        @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- source
    int   sent = 0;

    // Hold tvalid high from beat to beat; drop it only for an idle gap.
    task automatic send_byte(logic [7:0] b, logic rs, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= rs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, rs);
        sent++;
    endtask

    // Drop tvalid before the source waits on anything else.
    task automatic idle_src();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Build one 32-byte entry image.
    typedef logic [7:0] t_entry [32];

    function automatic t_entry rand_entry(int shape);
        t_entry e;
        int seq;
        for (int i = 0; i < 32; i++) e[i] = 8'($urandom_range(0, 255));
        if (e[0] == 8'h00) e[0] = 8'h41;
        case (shape)
            0: begin // short name, printable with some spaces
                for (int i = 0; i < 11; i++)
                    e[i] = ($urandom_range(0, 3) == 0) ? SPACE_CHAR
                                                       : 8'($urandom_range(33, 126));
                if (e[0] == SPACE_CHAR) e[0] = 8'h41;
                e[11] = $urandom_range(0, 1) ? 8'h10 : 8'h20;
            end
            1: e[11] = ATTR_LONG_NAME;
            2: e[0] = DELETED_MARK;
            3: e[11] = 8'h08;
            default: ;
        endcase
        if (shape == 1) begin
            seq = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) seq = $urandom_range(0, 63);
            e[0] = {$urandom_range(0, 1) ? 2'b01 : 2'b00, seq[5:0]};
            if ($urandom_range(0, 1)) e[0][7] = 1'b1;
        end
        return e;
    endfunction

    task automatic send_entry(t_entry e, bit rs_first);
        for (int i = 0; i < 32; i++) send_byte(e[i], rs_first && i == 0, 1'b1);
    endtask

    // Table: end, two-part and capped long names, short names, deleted, volume, end.
    typedef struct {
        logic [7:0] b;
        logic       rs;
    } t_row;

    t_row dir_rows[$];

    function automatic void add_entry(t_entry e, bit rs_first);
        for (int i = 0; i < 32; i++) dir_rows.push_back('{e[i], rs_first && i == 0});
    endfunction

    initial begin
        t_entry e;
        int     shape;
        ent_pos = '0;
        lfn_len = '0;
        lfn_on = 1'b0;
        dir_done = 1'b0;
        for (int i = 0; i < 32; i++) ent_buf[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An end marker right after reset gives one end beat with last set.
        dir_rows.push_back('{8'h00, 1'b0});
        // Ignored after the end; restart revives the stream.
        dir_rows.push_back('{8'hFF, 1'b0});
        dir_rows.push_back('{8'h00, 1'b0});

        // Long name 2 parts (0x42 then 0x01), then short entries; extremes in sizes.
        e = rand_entry(1); e[0] = 8'h42; add_entry(e, 1'b1);
        e = rand_entry(1); e[0] = 8'h01; add_entry(e, 1'b0);
        e = rand_entry(0);
        for (int i = 20; i < 32; i++) e[i] = 8'hFF;
        add_entry(e, 1'b0);
        e = rand_entry(0);
        for (int i = 20; i < 32; i++) e[i] = 8'h00;
        for (int i = 0; i < 11; i++) e[i] = SPACE_CHAR;
        add_entry(e, 1'b0);
        // Max sequence with flag: length capped, then empty-buffer name.
        e = rand_entry(1); e[0] = 8'h7F; add_entry(e, 1'b0);
        e = rand_entry(0); add_entry(e, 1'b0);
        e = rand_entry(2); add_entry(e, 1'b0);
        e = rand_entry(3); add_entry(e, 1'b0);
        dir_rows.push_back('{8'h00, 1'b0});

        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].rs, i != 0);

        // Random streams: mostly well-formed entries, some noise bytes.
        while (sent < 460) begin
            if (sent > 340 && sent < 380) begin
                // Let every expected beat drain before continuing.
                idle_src();
                wait (beats_due.size() == 0);
            end
            shape = $urandom_range(0, 9);
            if (shape < 5) shape = (shape < 2) ? 1 : 0;
            if (shape == 9) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
            end else if (shape == 8) begin
                send_byte(8'h00, 1'b1, 1'b1);
            end else begin
                e = rand_entry(shape);
                send_entry(e, $urandom_range(0, 15) == 0);
            end
        end

        idle_src();
        wait (beats_due.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && beats_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
